### sv/pfd_pkg.sv
// Shared types, widths and codes for the process queue with delete by pid.
package pfd_pkg;

   localparam int QUEUE_DEPTH_DEFAULT = 16;

   localparam int PID_W     = 22;
   localparam int PRIO_W    = 8;
   localparam int RUNTIME_W = 16;
   localparam int REC_W     = PID_W + PRIO_W + RUNTIME_W;
   localparam int OCC_W     = 5;
   localparam int MODE_W    = 2;
   localparam int STATUS_W  = 2;

   localparam int REQ_DATA_W = ((REC_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((REC_W + OCC_W + 7) / 8) * 8;

   localparam logic [MODE_W-1:0] MODE_PUSH   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_POP    = 2'd1;
   localparam logic [MODE_W-1:0] MODE_DELETE = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY     = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd3;

   typedef struct packed {
      logic [PID_W-1:0]     pid;
      logic [PRIO_W-1:0]    prio;
      logic [RUNTIME_W-1:0] runtime;
   } pfd_rec_type;

   typedef struct packed {
      logic push;
      logic shift_all;
      logic shift_del;
      logic load_match;
      logic scan;
   } pfd_cmd_type;

endpackage

### sv/pfd_cell.sv
// One queue cell: holds a record, takes part in push, pop, and delete compaction.
module pfd_cell
   import pfd_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT,
   parameter int CELL_INDEX  = 0
) (
   input  logic                               clock,
   input  logic                               reset,
   input  pfd_cmd_type                        cmd,
   input  logic [$clog2(QUEUE_DEPTH+1)-1:0]   count,
   input  logic [PID_W-1:0]                   key,
   input  pfd_rec_type                        push_rec,
   input  pfd_rec_type                        right_rec,
   input  logic                               seen_in,
   output pfd_rec_type                        rec_out,
   output logic                               seen_out,
   output logic                               hit_out,
   output pfd_rec_type                        hit_rec
);

   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   pfd_rec_type rec_ff;
   logic        match_ff;
   logic        seen_ff;
   logic        occupied;

   assign occupied = count > CW'(CELL_INDEX);
   assign seen_out = seen_ff | match_ff;
   assign hit_out  = match_ff & ~seen_ff;
   assign hit_rec  = hit_out ? rec_ff : '0;
   assign rec_out  = rec_ff;

   always_ff @(posedge clock) begin
      if (cmd.push && count == CW'(CELL_INDEX)) begin
         rec_ff <= push_rec;
      end else if (cmd.shift_all || (cmd.shift_del && seen_out)) begin
         rec_ff <= right_rec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_ff <= 1'b0;
         seen_ff  <= 1'b0;
      end else if (cmd.load_match) begin
         match_ff <= occupied && (rec_ff.pid == key);
         seen_ff  <= 1'b0;
      end else if (cmd.scan) begin
         seen_ff <= seen_in;
      end
   end

endmodule

### sv/process_fifo_with_delete_by_pid_core.sv
// Top level: ordered process queue built from a chain of cells, with delete by pid.
//
//   channel  direction  tdata (low bit up)                          tuser
//   req      in         pid_value, priority_value, runtime_value    mode
//   rsp      out        out_pid, out_priority, out_runtime, occupancy  status
//
// A push, a pop or an unused mode is carried out as its beat is taken; its result beat is registered.
// A delete first compares every cell against the key, then lets the first-match flag
// ripple one cell per cycle down the chain, and then, once the result register is free,
// closes the gap and registers the result.
// Reset clears the record count and the control state; cell contents stay unknown.
// A new beat is taken while the core is idle and the result register is empty or being drained.
module process_fifo_with_delete_by_pid_core
   import pfd_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // pid_value, priority_value, runtime_value
   input  logic [MODE_W-1:0]     req_tuser,  // mode
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // out_pid, out_priority, out_runtime, occupancy
   output logic [STATUS_W-1:0]   rsp_tuser   // status
);

   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int SW = (QUEUE_DEPTH > 2) ? $clog2(QUEUE_DEPTH - 1) : 1;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SCAN = 2'd1;
   localparam logic [1:0] S_DONE = 2'd2;

   logic [1:0]          state_ff, state_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [SW-1:0]       scan_ff, scan_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   pfd_rec_type         rsp_rec_ff, rsp_rec_in;
   logic [OCC_W-1:0]    rsp_occ_ff, rsp_occ_in;

   pfd_cmd_type cmd;
   pfd_rec_type push_rec;
   logic        req_beat;
   logic        rsp_free;
   logic        found;
   pfd_rec_type hit_any;

   pfd_rec_type              cell_rec  [QUEUE_DEPTH];
   pfd_rec_type              cell_hrec [QUEUE_DEPTH];
   logic [QUEUE_DEPTH-1:0]   cell_hit;
   logic [QUEUE_DEPTH:0]     seen_chain;

   assign push_rec.pid     = req_tdata[PID_W-1:0];
   assign push_rec.prio    = req_tdata[PID_W+PRIO_W-1:PID_W];
   assign push_rec.runtime = req_tdata[REC_W-1:PID_W+PRIO_W];

   assign rsp_free   = ~rsp_valid_ff | rsp_tready;
   assign req_tready = (state_ff == S_IDLE) && rsp_free;
   assign req_beat   = req_tvalid && req_tready;

   assign seen_chain[0] = 1'b0;
   assign found         = seen_chain[QUEUE_DEPTH];

   for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
      pfd_cell #(
         .QUEUE_DEPTH (QUEUE_DEPTH),
         .CELL_INDEX  (g)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .cmd       (cmd),
         .count     (count_ff),
         .key       (push_rec.pid),
         .push_rec  (push_rec),
         .right_rec ((g == QUEUE_DEPTH - 1) ? pfd_rec_type'('0) : cell_rec[(g + 1) % QUEUE_DEPTH]),
         .seen_in   (seen_chain[g]),
         .rec_out   (cell_rec[g]),
         .seen_out  (seen_chain[g+1]),
         .hit_out   (cell_hit[g]),
         .hit_rec   (cell_hrec[g])
      );
   end

   always_comb begin
      hit_any = '0;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         hit_any = hit_any | cell_hrec[i];
      end
   end

   always_comb begin
      cmd           = '0;
      state_in      = state_ff;
      count_in      = count_ff;
      scan_in       = scan_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_rec_in    = rsp_rec_ff;
      rsp_occ_in    = rsp_occ_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_beat) begin
               rsp_status_in = STATUS_OK;
               rsp_rec_in    = '0;
               rsp_valid_in  = 1'b1;
               case (req_tuser)
                  MODE_PUSH: begin
                     if (count_ff == CW'(QUEUE_DEPTH)) begin
                        rsp_status_in = STATUS_FULL;
                     end else begin
                        cmd.push = 1'b1;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  MODE_POP: begin
                     if (count_ff == '0) begin
                        rsp_status_in = STATUS_EMPTY;
                     end else begin
                        cmd.shift_all = 1'b1;
                        rsp_rec_in    = cell_rec[0];
                        count_in      = count_ff - 1'b1;
                     end
                  end
                  MODE_DELETE: begin
                     cmd.load_match = 1'b1;
                     rsp_valid_in   = 1'b0;
                     scan_in        = '0;
                     state_in       = S_SCAN;
                  end
                  default: begin
                  end
               endcase
               rsp_occ_in = OCC_W'(count_in);
            end
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            scan_in  = scan_ff + 1'b1;
            if (scan_ff == SW'(QUEUE_DEPTH - 2)) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               if (found) begin
                  cmd.shift_del = 1'b1;
                  count_in      = count_ff - 1'b1;
                  rsp_status_in = STATUS_OK;
                  rsp_rec_in    = hit_any;
               end else begin
                  rsp_status_in = STATUS_NOT_FOUND;
                  rsp_rec_in    = '0;
               end
               rsp_occ_in = OCC_W'(count_in);
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         scan_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         scan_ff      <= scan_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_rec_ff    <= rsp_rec_in;
      rsp_occ_ff    <= rsp_occ_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = RSP_DATA_W'({rsp_occ_ff, rsp_rec_ff.runtime, rsp_rec_ff.prio,
                                   rsp_rec_ff.pid});

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(QUEUE_DEPTH))
      else $error("record count exceeds queue depth");

   assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DONE |-> $onehot0(cell_hit))
      else $error("more than one cell flagged as the first pid match");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == STATUS_EMPTY) |-> rsp_occ_ff == '0)
      else $error("empty status reported with nonzero occupancy");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && rsp_free && found) |=> count_ff == $past(count_ff) - 1'b1)
      else $error("successful delete did not lower the record count");

endmodule
